// ===== hdl/fpfa_pkg.sv =====
// Shared types and constants of the fixed partition fit allocator.
// No dependencies; imported by every module of the block.
package fpfa_pkg;

  localparam int unsigned SizeW        = 24;
  localparam int unsigned FuncW        = 2;
  localparam int unsigned EntryW       = 4;
  localparam int unsigned ModeW        = 2;
  localparam int unsigned CountW       = 5;
  localparam int unsigned GrantIdxW    = 4;
  localparam int unsigned ApbDataW     = 32;
  localparam int unsigned ApbAddrW     = 3;
  localparam int unsigned DefNumBlocks = 16;

  // Item function codes
  localparam logic [FuncW-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FuncW-1:0] FUNC_REQUEST = 2'd1;
  localparam logic [FuncW-1:0] FUNC_CLEAR   = 2'd2;

  // Fit modes; the spare code behaves as first fit
  localparam logic [ModeW-1:0] MODE_FIRST = 2'd0;
  localparam logic [ModeW-1:0] MODE_BEST  = 2'd1;
  localparam logic [ModeW-1:0] MODE_WORST = 2'd2;

  // Register indexes (bit 2 of the byte address)
  localparam logic REG_FIT_MODE    = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

endpackage

// ===== hdl/fpfa_size_mem.sv =====
// Partition size store: one write port, one read port, registered read data.
// Depends on fpfa_pkg for the default data width.
module fpfa_size_mem import fpfa_pkg::*; #(
  parameter int unsigned Depth = DefNumBlocks,
  parameter int unsigned AddrW = 4,
  parameter int unsigned DataW = SizeW
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/fixed_partition_fit_allocator.sv =====
// Top level of the fixed partition fit allocator: command port, APB registers,
// scan sequencer and used marks. Depends on fpfa_pkg and fpfa_size_mem.
//
// A word is taken when start_i is high and busy_o is low. Every word gives
// exactly one result word: done_o pulses for one cycle with granted_o and
// granted_index_o valid in that cycle, and the receiver cannot stall it, so
// capture it when it appears. Load, clear and unused function codes, and a
// request made while block_count is zero, answer in the cycle after the word
// is taken and leave busy_o low, so such words can follow every cycle. A
// request with L = min(block_count, NUM_BLOCKS) partitions in play holds
// busy_o high for L cycles: the size memory is read one entry per cycle
// through its single read port and each entry is judged the cycle its data
// returns, so the result pulses L + 1 cycles after the request is taken and
// the next word may be taken in that same cycle. Sizes are kept across a
// clear item; used marks reset to zero and a clear item drops all of them at
// once. Change fit_mode and block_count only while no request is in flight.
module fixed_partition_fit_allocator import fpfa_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = DefNumBlocks
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command port
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [FuncW-1:0]      func_i,
  input  logic [EntryW-1:0]     entry_index_i,
  input  logic [SizeW-1:0]      size_value_i,
  output logic                  done_o,
  output logic                  granted_o,
  output logic [GrantIdxW-1:0]  granted_index_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ApbAddrW-1:0]   paddr,
  input  logic [ApbDataW-1:0]   pwdata,
  output logic [ApbDataW-1:0]   prdata,
  output logic                  pready
);

  localparam int unsigned IdxW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CntW = $clog2(NUM_BLOCKS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // configuration registers
  logic [ModeW-1:0]  fit_mode_q;
  logic [CountW-1:0] block_count_q;

  // sequencer
  logic              state_q, state_d;
  logic [CntW-1:0]   limit_q, limit_d;
  logic [CntW-1:0]   issue_q, issue_d;
  logic              pend_q, pend_d;
  logic [CntW-1:0]   pend_idx_q, pend_idx_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   pick_q, pick_d;
  logic [SizeW-1:0]  best_q, best_d;
  logic [SizeW-1:0]  req_size_q, req_size_d;
  logic [NUM_BLOCKS-1:0] used_q, used_d;

  // result word
  logic                 done_q, done_d;
  logic                 granted_q, granted_d;
  logic [GrantIdxW-1:0] gidx_q, gidx_d;

  logic              accept;
  logic              cfg_wr;
  logic [8:0]        entry_ext;
  logic              load_ok;
  logic [CntW-1:0]   limit_now;
  logic [IdxW-1:0]   rd_addr;
  logic [SizeW-1:0]  rd_data;
  logic [IdxW-1:0]   pidx;
  logic              cand;
  logic              take;
  logic              last;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // ---------------------------------------------------------------------------
  // APB registers: always ready, write on the access phase
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= MODE_FIRST;
      block_count_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FIT_MODE:    fit_mode_q    <= pwdata[ModeW-1:0];
        REG_BLOCK_COUNT: block_count_q <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FIT_MODE:    prdata = {{(ApbDataW-ModeW){1'b0}}, fit_mode_q};
      REG_BLOCK_COUNT: prdata = {{(ApbDataW-CountW){1'b0}}, block_count_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Size memory: loads write at acceptance, the scan reads one entry a cycle
  // ---------------------------------------------------------------------------
  assign entry_ext = 9'(entry_index_i);
  assign load_ok   = accept && (func_i == FUNC_LOAD) && (entry_ext < 9'(NUM_BLOCKS));

  // Start of a request reads entry zero; afterwards follow the issue counter
  assign rd_addr = accept ? '0 : issue_q[IdxW-1:0];

  fpfa_size_mem #(
    .Depth (NUM_BLOCKS),
    .AddrW (IdxW),
    .DataW (SizeW)
  ) u_size_mem (
    .clk_i     (clk_i),
    .wr_en_i   (load_ok),
    .wr_addr_i (entry_ext[IdxW-1:0]),
    .wr_data_i (size_value_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Saturate block_count to the table depth
  assign limit_now = (9'(block_count_q) > 9'(NUM_BLOCKS)) ? CntW'(NUM_BLOCKS)
                                                         : CntW'(block_count_q);

  // ---------------------------------------------------------------------------
  // Judge the entry whose data has just returned
  // ---------------------------------------------------------------------------
  assign pidx = pend_idx_q[IdxW-1:0];
  assign cand = pend_q && !used_q[pidx] && (rd_data >= req_size_q);

  // First fit (and the spare mode) keeps the earliest candidate; best and
  // worst fit replace only on a strictly better size, so ties stay low.
  assign take = cand && (!found_q ||
                         ((fit_mode_q == MODE_BEST)  && (rd_data < best_q)) ||
                         ((fit_mode_q == MODE_WORST) && (rd_data > best_q)));

  assign last = pend_q && (pend_idx_q == (limit_q - CntW'(1)));

  always_comb begin
    state_d    = state_q;
    limit_d    = limit_q;
    issue_d    = issue_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    found_d    = found_q;
    pick_d     = pick_q;
    best_d     = best_q;
    req_size_d = req_size_q;
    used_d     = used_q;
    done_d     = 1'b0;
    granted_d  = 1'b0;
    gidx_d     = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((func_i == FUNC_REQUEST) && (limit_now != '0)) begin
            // entry zero is being read now; its data arrives next cycle
            state_d    = ST_SCAN;
            limit_d    = limit_now;
            issue_d    = CntW'(1);
            pend_d     = 1'b1;
            pend_idx_d = '0;
            found_d    = 1'b0;
            req_size_d = size_value_i;
          end else begin
            // everything else answers at once with no grant
            done_d = 1'b1;
            if (func_i == FUNC_CLEAR) begin
              used_d = '0;
            end
          end
        end
      end

      ST_SCAN: begin
        // advance the read pointer while entries remain
        if (issue_q < limit_q) begin
          pend_d     = 1'b1;
          pend_idx_d = issue_q;
          issue_d    = issue_q + CntW'(1);
        end
        if (take) begin
          found_d = 1'b1;
          pick_d  = pidx;
          best_d  = rd_data;
        end
        if (last) begin
          // commit: mark the winner used and hand out the result word
          state_d   = ST_IDLE;
          pend_d    = 1'b0;
          done_d    = 1'b1;
          granted_d = found_d;
          if (found_d) begin
            used_d[pick_d] = 1'b1;
            gidx_d         = GrantIdxW'(pick_d);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      limit_q    <= '0;
      issue_q    <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      found_q    <= 1'b0;
      used_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      limit_q    <= limit_d;
      issue_q    <= issue_d;
      pend_q     <= pend_d;
      pend_idx_q <= pend_idx_d;
      found_q    <= found_d;
      used_q     <= used_d;
      done_q     <= done_d;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    pick_q     <= pick_d;
    best_q     <= best_d;
    req_size_q <= req_size_d;
    granted_q  <= granted_d;
    gidx_q     <= gidx_d;
  end

  assign done_o          = done_q;
  assign granted_o       = granted_q;
  assign granted_index_o = gidx_q;

endmodule

// ===== tb/tb_fixed_partition_fit_allocator.sv =====
// Self-checking testbench for the fixed partition fit allocator: directed script, then random
// command words under three sender idling profiles, checked against an in-bench allocator model.
// Depends on fpfa_pkg and the fixed_partition_fit_allocator RTL.
module tb_fixed_partition_fit_allocator import fpfa_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBlocks   = DefNumBlocks;
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned SubPhases   = 8;   // register settings per idling profile
  localparam int unsigned WordsPerSet = 23;  // random words per register setting

  // Codes the package leaves unnamed: spare function and spare fit mode
  localparam logic [FuncW-1:0] FUNC_SPARE = 2'd3;
  localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [EntryW-1:0] idx;
    logic [SizeW-1:0]  size;
  } cmd_t;

  typedef struct packed {
    logic                 granted;
    logic [GrantIdxW-1:0] index;
  } grant_t;

  typedef enum bit {ROW_WORD, ROW_REG} row_kind_e;

  // One line of the directed script: either a command word or a register write
  typedef struct {
    row_kind_e            kind;
    logic                 reg_sel;
    logic [ApbDataW-1:0]  value;
    cmd_t                 cmd;
    bit                   typed;  // expected result typed in, not predicted
    grant_t               want;
  } row_t;

  localparam grant_t NO_GRANT = '0;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [FuncW-1:0]     func_i = '0;
  logic [EntryW-1:0]    entry_index_i = '0;
  logic [SizeW-1:0]     size_value_i = '0;
  logic                 done_o;
  logic                 granted_o;
  logic [GrantIdxW-1:0] granted_index_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ApbAddrW-1:0]  paddr = '0;
  logic [ApbDataW-1:0]  pwdata = '0;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  // Allocator model: partition table, used marks and the two registers
  logic [SizeW-1:0]     size_tab [NumBlocks];
  logic [NumBlocks-1:0] used_mask = '0;
  logic [ModeW-1:0]     cfg_mode = MODE_FIRST;
  logic [CountW-1:0]    cfg_count = '0;

  grant_t      pending_grants [$];  // one expected result word per accepted command word
  row_t        script [$];
  int unsigned idle_pct = 6;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned grants_seen = 0;
  int unsigned reg_writes = 0;

  fixed_partition_fit_allocator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .entry_index_i   (entry_index_i),
    .size_value_i    (size_value_i),
    .done_o          (done_o),
    .granted_o       (granted_o),
    .granted_index_o (granted_index_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Report the first few failures in full, count the rest
  function automatic void note_error(string msg);
    errors++;
    if (errors <= ReportLimit) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endfunction

  // Advance the model by one command word and return the result word it should give.
  // Best and worst fit keep the first candidate on a tie, so strict compares only;
  // first fit (and the spare mode) never moves off the first candidate.
  function automatic grant_t allocate(cmd_t c);
    grant_t      g;
    int unsigned limit;
    bit          found;
    int unsigned pick;
    g = NO_GRANT;
    found = 1'b0;
    pick = 0;
    case (c.func)
      FUNC_LOAD: size_tab[c.idx] = c.size;
      FUNC_CLEAR: used_mask = '0;
      FUNC_REQUEST: begin
        // block_count above the table size saturates
        limit = (cfg_count > NumBlocks) ? NumBlocks : cfg_count;
        for (int unsigned j = 0; j < limit; j++) begin
          if (!used_mask[j] && size_tab[j] >= c.size) begin
            if (!found) begin
              found = 1'b1;
              pick = j;
            end else if (cfg_mode == MODE_BEST && size_tab[j] < size_tab[pick]) begin
              pick = j;
            end else if (cfg_mode == MODE_WORST && size_tab[j] > size_tab[pick]) begin
              pick = j;
            end
          end
        end
        if (found) begin
          used_mask[pick] = 1'b1;
          g.granted = 1'b1;
          g.index = pick[GrantIdxW-1:0];
        end
      end
      default: ;  // spare function code does nothing
    endcase
    return g;
  endfunction

  // Sizes cluster low so ties and near misses are common; extremes turn up regularly
  function automatic logic [SizeW-1:0] pick_size();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return r[SizeW-1:0];
      default: return SizeW'($urandom_range(0, 63));
    endcase
  endfunction

  // Mostly requests, with enough loads and clears to keep partitions turning over
  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned r;
    c.idx = EntryW'($urandom_range(0, NumBlocks - 1));
    c.size = pick_size();
    r = $urandom_range(0, 99);
    if (r < 60) begin
      c.func = FUNC_REQUEST;
    end else if (r < 80) begin
      c.func = FUNC_LOAD;
    end else if (r < 92) begin
      c.func = FUNC_CLEAR;
    end else begin
      c.func = FUNC_SPARE;
    end
    return c;
  endfunction

  function automatic row_t mk_word(logic [FuncW-1:0] f, logic [EntryW-1:0] i,
                                   logic [SizeW-1:0] s, bit typed, grant_t want);
    row_t r;
    r.kind = ROW_WORD;
    r.reg_sel = 1'b0;
    r.value = '0;
    r.cmd = '{func: f, idx: i, size: s};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic row_t mk_reg(logic sel, logic [ApbDataW-1:0] v);
    row_t r;
    r.kind = ROW_REG;
    r.reg_sel = sel;
    r.value = v;
    r.cmd = '0;
    r.typed = 1'b0;
    r.want = NO_GRANT;
    return r;
  endfunction

  // Offer one command word, idling first at the current rate; hold it until taken.
  // Start stays high from one word to the next when no idle cycle falls between.
  task automatic send_word(cmd_t c, bit typed, grant_t want);
    grant_t predicted;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    func_i = c.func;
    entry_index_i = c.idx;
    size_value_i = c.size;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predicted = allocate(c);
    pending_grants.push_back(typed ? want : predicted);
    words_sent++;
    if (c.func == FUNC_REQUEST) begin
      requests_sent++;
    end
  endtask

  // Drop start and wait until every outstanding result word has come back
  task automatic quiesce();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
  endtask

  task automatic read_reg(logic sel, logic [ApbDataW-1:0] want);
    logic [ApbDataW-1:0] mask;
    mask = (sel == REG_FIT_MODE) ? ApbDataW'((1 << ModeW) - 1) : ApbDataW'((1 << CountW) - 1);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {sel, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if ((prdata & mask) !== (want & mask)) begin
      note_error($sformatf("register %0d read back 0x%0h, expected 0x%0h",
                           sel, prdata & mask, want & mask));
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Setup and access phase, then read the register back
  task automatic write_reg(logic sel, logic [ApbDataW-1:0] v);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {sel, 2'b00};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (sel == REG_FIT_MODE) begin
      cfg_mode = v[ModeW-1:0];
    end else begin
      cfg_count = v[CountW-1:0];
    end
    reg_writes++;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    read_reg(sel, v);
  endtask

  // Compare every result word with the oldest expectation, field by field
  always @(posedge clk_i) begin : score_results
    grant_t got;
    grant_t want;
    if (rst_ni && done_o === 1'b1) begin
      got = {granted_o, granted_index_o};
      results_seen++;
      if (got.granted === 1'b1) begin
        grants_seen++;
      end
      if (pending_grants.size() == 0) begin
        note_error($sformatf("result word with nothing outstanding: granted %0b index %0d",
                             got.granted, got.index));
      end else begin
        want = pending_grants.pop_front();
        if (got.granted !== want.granted || got.index !== want.index) begin
          note_error($sformatf("result mismatch: granted %0b index %0d, expected %0b index %0d",
                               got.granted, got.index, want.granted, want.index));
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d result words still outstanding",
               cycle_count, pending_grants.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [ModeW-1:0]  mode;
    logic [CountW-1:0] count;
    row_t              r;

    // Directed script. Every partition is loaded before block_count rises above zero,
    // so no request ever looks at a size that was never written.
    // Zero block_count: nothing to pick from, the request is refused
    script.push_back(mk_word(FUNC_REQUEST, 4'd0, 24'd0, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_SPARE, 4'd15, 24'hFFFFFF, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_CLEAR, 4'd0, 24'd0, 1'b1, NO_GRANT));
    // Load the whole table: duplicates for the tie rules, zero and full-scale sizes
    script.push_back(mk_word(FUNC_LOAD, 4'd0, 24'd100, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd1, 24'hFFFFFF, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd2, 24'd50, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd3, 24'd100, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd4, 24'd0, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd5, 24'd200, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd6, 24'd50, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd7, 24'hFFFFFF, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd8, 24'd1000, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd9, 24'd999, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd10, 24'd1000, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd11, 24'd7, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd12, 24'd8, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd13, 24'd9, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd14, 24'd10, 1'b1, NO_GRANT));
    script.push_back(mk_word(FUNC_LOAD, 4'd15, 24'h800000, 1'b1, NO_GRANT));
    // Oversized block_count saturates to the full table; best fit, tie on the smallest
    script.push_back(mk_reg(REG_BLOCK_COUNT, 32'd31));
    script.push_back(mk_reg(REG_FIT_MODE, 32'(MODE_BEST)));
    script.push_back(mk_word(FUNC_REQUEST, 4'd0, 24'd60, 1'b0, NO_GRANT));
    script.push_back(mk_word(FUNC_REQUEST, 4'd0, 24'd60, 1'b0, NO_GRANT));
    // Worst fit with a tie on the largest
    script.push_back(mk_reg(REG_FIT_MODE, 32'(MODE_WORST)));
    script.push_back(mk_word(FUNC_REQUEST, 4'd0, 24'd0, 1'b0, NO_GRANT));
    // Spare mode acts as first fit; full-scale request, then nothing left that big
    script.push_back(mk_reg(REG_FIT_MODE, 32'(MODE_SPARE)));
    script.push_back(mk_word(FUNC_REQUEST, 4'd0, 24'hFFFFFF, 1'b0, NO_GRANT));
    script.push_back(mk_word(FUNC_REQUEST, 4'd0, 24'hFFFFFF, 1'b0, NO_GRANT));
    // Clear keeps the sizes but frees every partition
    script.push_back(mk_word(FUNC_CLEAR, 4'd0, 24'd0, 1'b1, NO_GRANT));
    script.push_back(mk_reg(REG_FIT_MODE, 32'(MODE_FIRST)));
    script.push_back(mk_word(FUNC_REQUEST, 4'd0, 24'd1, 1'b0, NO_GRANT));

    // Hold reset, then release it away from the sampling edge
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Both registers come out of reset at zero
    read_reg(REG_FIT_MODE, 32'(MODE_FIRST));
    read_reg(REG_BLOCK_COUNT, 32'd0);

    foreach (script[k]) begin
      r = script[k];
      if (r.kind == ROW_REG) begin
        quiesce();
        write_reg(r.reg_sel, r.value);
      end else begin
        send_word(r.cmd, r.typed, r.want);
      end
    end

    // Random part: sender idles rarely, then mostly, then never
    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 6 : (p == 1) ? 73 : 0;
      for (int s = 0; s < SubPhases; s++) begin
        if (s == 0) begin
          mode = MODE_FIRST;
          count = CountW'(NumBlocks);
        end else begin
          mode = ModeW'($urandom_range(0, 3));
          case ($urandom_range(0, 5))
            0: count = '0;
            1: count = '1;
            2: count = CountW'($urandom_range(NumBlocks + 1, 30));
            3: count = CountW'(1);
            default: count = CountW'($urandom_range(2, NumBlocks));
          endcase
        end
        quiesce();
        write_reg(REG_FIT_MODE, 32'(mode));
        write_reg(REG_BLOCK_COUNT, 32'(count));
        repeat (WordsPerSet) send_word(random_cmd(), 1'b0, NO_GRANT);
      end
    end

    // Drain, then keep watching the result port for any stray result word
    quiesce();
    repeat (NumBlocks + 4) @(posedge clk_i);

    $display("Summary: %0d command words (%0d requests), %0d results, %0d grants,",
             words_sent, requests_sent, results_seen, grants_seen);
    $display("         %0d register writes over all fit modes and block counts, %0d errors",
             reg_writes, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
